// ===== design/fpmm_pkg.sv =====
`timescale 1ns / 1ps

package fpmm_pkg;

  localparam int MAX_DIM_DEFAULT    = 8;
  localparam int VALUE_BITS_DEFAULT = 16;

  localparam int IDX_BITS  = 3;
  localparam int DIM_BITS  = 4;
  localparam int SUM_BITS  = 35;
  localparam int FUNC_BITS = 2;
  localparam int CFG_ADDR_BITS = 2;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

  // Input function codes.
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE_A = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE_B = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_RUN     = 2'd2;

  // Command kinds carried from the front to the back.
  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_RUN     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COLS_B    = 2'd2;

  // Command queue and result queue sizes.
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_BITS = 2;
  localparam int CQ_CNT_BITS = 3;
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_PTR_BITS = 2;
  localparam int RQ_CNT_BITS = 3;

  typedef struct packed {
    logic [IDX_BITS-1:0] m_last;
    logic [IDX_BITS-1:0] n_last;
    logic [IDX_BITS-1:0] p_last;
  } dims_t;

  // Largest index along one dimension: zero acts as one, oversize as max_dim.
  function automatic logic [IDX_BITS-1:0] dim_last(input logic [DIM_BITS-1:0] d,
                                                   input int max_dim);
    logic [IDX_BITS-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (int'(d) > max_dim) begin
      r = IDX_BITS'(max_dim - 1);
    end else begin
      r = IDX_BITS'(d - 4'd1);
    end
    return r;
  endfunction

endpackage

// ===== design/fpmm_ram.sv =====
`timescale 1ns / 1ps

module fpmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fpmm_front.sv =====
`timescale 1ns / 1ps

module fpmm_front #(
  parameter int MAX_DIM    = fpmm_pkg::MAX_DIM_DEFAULT,
  parameter int VALUE_BITS = fpmm_pkg::VALUE_BITS_DEFAULT,
  parameter int AW         = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fpmm_pkg::FUNC_BITS-1:0] func,
  input  logic [fpmm_pkg::IDX_BITS-1:0]  row,
  input  logic [fpmm_pkg::IDX_BITS-1:0]  col,
  input  logic signed [VALUE_BITS-1:0]   value,
  output logic                           cmd_valid,
  input  logic                           cmd_pop,
  output logic [1:0]                     cmd_kind,
  output logic [AW-1:0]                  cmd_addr,
  output logic [VALUE_BITS-1:0]          cmd_value
);

  import fpmm_pkg::*;

  logic [1:0]            q_kind  [CQ_DEPTH];
  logic [AW-1:0]         q_addr  [CQ_DEPTH];
  logic [VALUE_BITS-1:0] q_value [CQ_DEPTH];
  logic [CQ_PTR_BITS-1:0] wr_ptr;
  logic [CQ_PTR_BITS-1:0] rd_ptr;
  logic [CQ_CNT_BITS-1:0] count;

  logic       idx_ok;
  logic       keep;
  logic [1:0] kind;
  logic       push;
  logic [AW-1:0] addr;

  // Writes outside the store and unused codes are accepted and dropped here.
  always_comb begin
    idx_ok = ({1'b0, row} < 4'(MAX_DIM)) && ({1'b0, col} < 4'(MAX_DIM));
    addr   = AW'(32'(row) * MAX_DIM + 32'(col));
    case (func)
      FUNC_WRITE_A: begin
        keep = idx_ok;
        kind = CMD_WRITE_A;
      end
      FUNC_WRITE_B: begin
        keep = idx_ok;
        kind = CMD_WRITE_B;
      end
      FUNC_RUN: begin
        keep = 1'b1;
        kind = CMD_RUN;
      end
      default: begin
        keep = 1'b0;
        kind = CMD_RUN;
      end
    endcase
  end

  assign in_stall  = (count == CQ_CNT_BITS'(CQ_DEPTH));
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (count != '0);
  assign cmd_kind  = q_kind[rd_ptr];
  assign cmd_addr  = q_addr[rd_ptr];
  assign cmd_value = q_value[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr]  <= kind;
      q_addr[wr_ptr]  <= addr;
      q_value[wr_ptr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/fpmm_back.sv =====
`timescale 1ns / 1ps

module fpmm_back #(
  parameter int MAX_DIM    = fpmm_pkg::MAX_DIM_DEFAULT,
  parameter int VALUE_BITS = fpmm_pkg::VALUE_BITS_DEFAULT,
  parameter int AW         = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  logic [1:0]                    cmd_kind,
  input  logic [AW-1:0]                 cmd_addr,
  input  logic [VALUE_BITS-1:0]         cmd_value,
  input  fpmm_pkg::dims_t               dims,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fpmm_pkg::IDX_BITS-1:0] out_row,
  output logic [fpmm_pkg::IDX_BITS-1:0] out_col,
  output logic signed [fpmm_pkg::SUM_BITS-1:0] sum,
  output logic                          last
);

  import fpmm_pkg::*;

  localparam int PROD_BITS = 2 * VALUE_BITS;

  // Run sequencer.
  logic                running;
  logic [IDX_BITS-1:0] i_cnt;
  logic [IDX_BITS-1:0] j_cnt;
  logic [IDX_BITS-1:0] k_cnt;
  logic [RQ_CNT_BITS-1:0] reserved;

  logic issue;
  logic elem_start;
  logic start;
  logic a_we;
  logic b_we;
  logic out_pop;
  logic issue_lastk;
  logic issue_last;
  logic [AW-1:0] a_raddr;
  logic [AW-1:0] b_raddr;
  logic [VALUE_BITS-1:0] a_rdata;
  logic [VALUE_BITS-1:0] b_rdata;

  // MAC pipeline.
  logic                s1_valid;
  logic                s1_first;
  logic                s1_lastk;
  logic                s1_last;
  logic [IDX_BITS-1:0] s1_row;
  logic [IDX_BITS-1:0] s1_col;
  logic                s2_valid;
  logic                s2_first;
  logic                s2_lastk;
  logic                s2_last;
  logic [IDX_BITS-1:0] s2_row;
  logic [IDX_BITS-1:0] s2_col;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [63:0]          prod_wide;
  logic [SUM_BITS-1:0]         prod_term;
  logic [SUM_BITS-1:0]         acc;
  logic [SUM_BITS-1:0]         acc_next;
  logic                        rq_push;

  // Result queue.
  logic [IDX_BITS-1:0] rq_row  [RQ_DEPTH];
  logic [IDX_BITS-1:0] rq_col  [RQ_DEPTH];
  logic [SUM_BITS-1:0] rq_sum  [RQ_DEPTH];
  logic                rq_last [RQ_DEPTH];
  logic [RQ_PTR_BITS-1:0] rq_wr;
  logic [RQ_PTR_BITS-1:0] rq_rd;
  logic [RQ_CNT_BITS-1:0] rq_count;

  assign cmd_pop = cmd_valid && !running;
  assign a_we    = cmd_pop && (cmd_kind == CMD_WRITE_A);
  assign b_we    = cmd_pop && (cmd_kind == CMD_WRITE_B);
  assign start   = cmd_pop && (cmd_kind == CMD_RUN);

  // A new result element is started only when its slot in the result queue
  // is guaranteed, so the MAC pipeline itself never has to stop.
  assign issue       = running && ((k_cnt != '0) || (reserved < RQ_CNT_BITS'(RQ_DEPTH)));
  assign elem_start  = issue && (k_cnt == '0);
  assign issue_lastk = (k_cnt == dims.n_last);
  assign issue_last  = (i_cnt == dims.m_last) && (j_cnt == dims.p_last);
  assign out_pop     = out_valid && !out_stall;

  assign a_raddr = AW'(32'(i_cnt) * MAX_DIM + 32'(k_cnt));
  assign b_raddr = AW'(32'(k_cnt) * MAX_DIM + 32'(j_cnt));

  fpmm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_DIM * MAX_DIM),
    .AW    (AW)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (cmd_addr),
    .wdata (cmd_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  fpmm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_DIM * MAX_DIM),
    .AW    (AW)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (cmd_addr),
    .wdata (cmd_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
      reserved <= '0;
    end else begin
      if (start) begin
        running <= 1'b1;
        i_cnt   <= '0;
        j_cnt   <= '0;
        k_cnt   <= '0;
      end else if (issue) begin
        if (!issue_lastk) begin
          k_cnt <= k_cnt + 1'b1;
        end else begin
          k_cnt <= '0;
          if (j_cnt != dims.p_last) begin
            j_cnt <= j_cnt + 1'b1;
          end else begin
            j_cnt <= '0;
            if (i_cnt != dims.m_last) begin
              i_cnt <= i_cnt + 1'b1;
            end else begin
              running <= 1'b0;
            end
          end
        end
      end
      if (elem_start && !out_pop) begin
        reserved <= reserved + 1'b1;
      end else if (!elem_start && out_pop) begin
        reserved <= reserved - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (k_cnt == '0);
    s1_lastk <= issue_lastk;
    s1_last  <= issue_last;
    s1_row   <= i_cnt;
    s1_col   <= j_cnt;
    s2_first <= s1_first;
    s2_lastk <= s1_lastk;
    s2_last  <= s1_last;
    s2_row   <= s1_row;
    s2_col   <= s1_col;
    prod     <= $signed(a_rdata) * $signed(b_rdata);
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  // The sum is kept modulo 2^35; wider products simply wrap.
  always_comb begin
    prod_wide = 64'(prod);
    prod_term = prod_wide[SUM_BITS-1:0];
    acc_next  = s2_first ? prod_term : (acc + prod_term);
  end

  assign rq_push = s2_valid && s2_lastk;

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_row[rq_wr]  <= s2_row;
      rq_col[rq_wr]  <= s2_col;
      rq_sum[rq_wr]  <= acc_next;
      rq_last[rq_wr] <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      if (rq_push) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (out_pop) begin
        rq_rd <= rq_rd + 1'b1;
      end
      if (rq_push && !out_pop) begin
        rq_count <= rq_count + 1'b1;
      end else if (!rq_push && out_pop) begin
        rq_count <= rq_count - 1'b1;
      end
    end
  end

  assign out_valid = (rq_count != '0);
  assign out_row   = rq_row[rq_rd];
  assign out_col   = rq_col[rq_rd];
  assign sum       = rq_sum[rq_rd];
  assign last      = rq_last[rq_rd];

endmodule

// ===== design/fixed_point_matrix_multiply.sv =====
`timescale 1ns / 1ps

// Fixed-point matrix multiply, C = A * B, elements signed Q8.8, sums Q19.16.
// Input channel (in_valid / in_stall): func 0 writes value into A at (row, col),
// func 1 writes B, func 2 starts a run. Out-of-range writes and func 3 are
// accepted and dropped. Output channel (out_valid / out_stall): a run gives
// one beat per element of C in row-major order, last set on the final one.
// Dimensions come from the write port (cfg_wr_en, cfg_addr, cfg_wdata): 0 rows
// of A, 1 inner dimension, 2 columns of B; write them only while idle.
// Load items go at one per cycle while the command queue has room. A single
// multiply-accumulate unit reads one A and one B entry per cycle from the two
// store RAMs unless the result queue has no free slot; each product passes the
// RAM read and product registers before it is accumulated into its sum.
// A four-entry command queue sits between the input and the MAC sequencer and
// a four-entry result queue sits at the output. When the receiver stalls, the
// sequencer pauses at the next element boundary once four results are
// outstanding, and in_stall rises when the command queue fills.
// Reset empties both queues, stops any run and sets all dimensions to 8; the
// A and B stores are not cleared and must be written before they are used.
module fixed_point_matrix_multiply #(
  parameter int MAX_DIM    = fpmm_pkg::MAX_DIM_DEFAULT,
  parameter int VALUE_BITS = fpmm_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [fpmm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [fpmm_pkg::DIM_BITS-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fpmm_pkg::FUNC_BITS-1:0]      func,
  input  logic [fpmm_pkg::IDX_BITS-1:0]       row,
  input  logic [fpmm_pkg::IDX_BITS-1:0]       col,
  input  logic signed [VALUE_BITS-1:0]        value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fpmm_pkg::IDX_BITS-1:0]       out_row,
  output logic [fpmm_pkg::IDX_BITS-1:0]       out_col,
  output logic signed [fpmm_pkg::SUM_BITS-1:0] sum,
  output logic                                last
);

  import fpmm_pkg::*;

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  logic [DIM_BITS-1:0] rows_a;
  logic [DIM_BITS-1:0] inner_dim;
  logic [DIM_BITS-1:0] cols_b;
  dims_t               dims;

  logic                  cmd_valid;
  logic                  cmd_pop;
  logic [1:0]            cmd_kind;
  logic [AW-1:0]         cmd_addr;
  logic [VALUE_BITS-1:0] cmd_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ROWS_A:    rows_a    <= cfg_wdata;
        REG_INNER_DIM: inner_dim <= cfg_wdata;
        REG_COLS_B:    cols_b    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dims.m_last = dim_last(rows_a, MAX_DIM);
    dims.n_last = dim_last(inner_dim, MAX_DIM);
    dims.p_last = dim_last(cols_b, MAX_DIM);
  end

  fpmm_front #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .row       (row),
    .col       (col),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_kind  (cmd_kind),
    .cmd_addr  (cmd_addr),
    .cmd_value (cmd_value)
  );

  fpmm_back #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_kind  (cmd_kind),
    .cmd_addr  (cmd_addr),
    .cmd_value (cmd_value),
    .dims      (dims),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .sum       (sum),
    .last      (last)
  );

endmodule
